// ===== sv/pst_pkg.sv =====
// shared types and constants for the priority schedule timing block
package pst_pkg;

  localparam int MAX_JOBS = 32;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int PRIO_W   = 8;
  localparam int BURST_W  = 16;
  localparam int JOBNUM_W = 7;
  localparam int TIME_W   = 22;
  localparam int SUM_W    = 28;
  localparam int STEP_W   = $clog2(SUM_W);

  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  priority_req;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   job_priority;
    logic [JOBNUM_W-1:0] job_number;
    logic [BURST_W-1:0]  job_burst;
    logic [TIME_W-1:0]   waiting_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [TIME_W-1:0]   avg_waiting;
    logic [TIME_W-1:0]   avg_turnaround;
    logic                overflowed;
    logic                last_out;
  } out_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [IDX_W-1:0]   job_id;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [CNT_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SUM_W-1:0]   quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_FIRST,
    S_SCAN,
    S_SWAP,
    S_DW_GO,
    S_DW,
    S_DT_GO,
    S_DT,
    S_PUSH
  } state_t;

endpackage

// ===== sv/pst_ram.sv =====
// generic single write port ram with registered read
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pst_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module pst_div import pst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  always_comb begin
    shifted  = {rem_r, dvd_r[SUM_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    fits     = shifted >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W - 1);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_nxt = step_r - STEP_W'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// ===== sv/priority_schedule_times_top.sv =====
// top level: job store, selection sort sequencer, timing sums and result register
//
// in_* channel: one beat per job (burst, priority, last flag), valid/ready.
// Jobs load at one beat per cycle while the block is in its load phase; a job
// arriving with MAX_JOBS jobs already stored is dropped and flags overflow.
// The beat marked last closes the batch; in_ready then drops until the last
// result of the batch has been loaded into the output register.
// out_* channel: one beat per stored job in priority order, valid/ready,
// held in an output register. Each slot takes one ram read per remaining job
// through a single priority comparator, then a swap state records the slot and
// a push state loads the output register once it is free. Before the final
// beat the averages go through one shared bit-serial divider, twice.
// A stalled receiver holds the sequencer at the output register; no beat is
// lost and the order is kept.
// Reset (rst_n low, synchronous) empties the batch and clears all sums and
// flags; the job ram needs no clearing since only loaded entries are read.
module priority_schedule_times_top import pst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [TIME_W-1:0] run_r, run_nxt;
  logic [SUM_W-1:0] sum_w_r, sum_w_nxt;
  logic [SUM_W-1:0] sum_t_r, sum_t_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] sel_r, sel_nxt;
  entry_t           cur_r, cur_nxt;
  entry_t           best_r, best_nxt;
  out_t             res_r, res_nxt;
  out_t             out_r, out_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             slot_free;
  logic             last_pos;
  logic [CNT_W-1:0] arr_idx;
  logic [TIME_W-1:0] turn;

  pst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_JOBS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  pst_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    last_pos  = (i_r + CNT_W'(1)) == count_r;
    arr_idx   = j_r - CNT_W'(1);
    turn      = run_r + TIME_W'(best_r.burst);

    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    run_nxt       = run_r;
    sum_w_nxt     = sum_w_r;
    sum_t_nxt     = sum_t_r;
    out_valid_nxt = out_valid_r && !out_ready;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sel_nxt       = sel_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_nxt       = out_r;

    in_ready         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = sel_r;
    mem_wdata        = cur_r;
    mem_raddr        = j_r[IDX_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = sum_w_r;
    div_req.divisor  = count_r;

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_JOBS)) begin
            mem_we           = 1'b1;
            mem_waddr        = count_r[IDX_W-1:0];
            mem_wdata.prio   = in_data.priority_req;
            mem_wdata.burst  = in_data.burst_time;
            mem_wdata.job_id = count_r[IDX_W-1:0];
            count_nxt        = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.is_last) begin
            i_nxt     = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        mem_raddr = i_r[IDX_W-1:0];
        j_nxt     = i_r + CNT_W'(1);
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cur_nxt  = mem_rdata;
        best_nxt = mem_rdata;
        sel_nxt  = i_r[IDX_W-1:0];
        if (j_r < count_r) begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_SWAP;
        end
      end
      S_SCAN: begin
        if (mem_rdata.prio < best_r.prio) begin
          best_nxt = mem_rdata;
          sel_nxt  = arr_idx[IDX_W-1:0];
        end
        if (j_r < count_r) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        mem_we                  = 1'b1;
        res_nxt.job_priority    = best_r.prio;
        res_nxt.job_number      = JOBNUM_W'(best_r.job_id) + JOBNUM_W'(1);
        res_nxt.job_burst       = best_r.burst;
        res_nxt.waiting_time    = run_r;
        res_nxt.turnaround_time = turn;
        res_nxt.avg_waiting     = '0;
        res_nxt.avg_turnaround  = '0;
        res_nxt.overflowed      = ovf_r;
        res_nxt.last_out        = last_pos;
        run_nxt                 = turn;
        sum_w_nxt               = sum_w_r + SUM_W'(run_r);
        sum_t_nxt               = sum_t_r + SUM_W'(turn);
        state_nxt               = last_pos ? S_DW_GO : S_PUSH;
      end
      S_DW_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_DW;
      end
      S_DW: begin
        if (div_rsp.done) begin
          res_nxt.avg_waiting = div_rsp.quotient[TIME_W-1:0];
          state_nxt           = S_DT_GO;
        end
      end
      S_DT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_t_r;
        state_nxt        = S_DT;
      end
      S_DT: begin
        div_req.dividend = sum_t_r;
        if (div_rsp.done) begin
          res_nxt.avg_turnaround = div_rsp.quotient[TIME_W-1:0];
          state_nxt              = S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if (res_r.last_out) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            run_nxt   = '0;
            sum_w_nxt = '0;
            sum_t_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_START;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      run_r       <= '0;
      sum_w_r     <= '0;
      sum_t_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      run_r       <= run_nxt;
      sum_w_r     <= sum_w_nxt;
      sum_t_r     <= sum_t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    sel_r  <= sel_nxt;
    cur_r  <= cur_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sim/tb_top.sv =====
// testbench for priority_schedule_times_top: batch scheduling order, timing sums and averages
module tb_top;
  import pst_pkg::*;

  localparam int RAND_ITEMS = 315;
  localparam int LONG_HOLD  = 1500;
  localparam int WATCHDOG   = 20000;
  localparam int TAIL_WAIT  = 120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  priority_schedule_times_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // jobs of the batch being loaded, in arrival order
  logic [BURST_W-1:0] pend_burst [MAX_JOBS];
  logic [PRIO_W-1:0]  pend_prio  [MAX_JOBS];
  logic [5:0]         pend_id    [MAX_JOBS];
  int                 pend_cnt;
  bit                 pend_ovf;

  out_t expected_slots[$];
  int   fail_cnt;
  int   idle_cycles;
  int   burst_left;
  int   rand_sent;
  int   hold_token;

  function automatic void close_batch();
    int                 n;
    int                 sel;
    logic [PRIO_W-1:0]  tp;
    logic [BURST_W-1:0] tb;
    logic [5:0]         ti;
    logic [TIME_W-1:0]  run_wait;
    logic [TIME_W-1:0]  turn;
    logic [SUM_W-1:0]   sum_w;
    logic [SUM_W-1:0]   sum_t;
    out_t               slots [MAX_JOBS];
    n = pend_cnt;
    for (int i = 0; i < n; i++) begin
      sel = i;
      for (int j = i + 1; j < n; j++) begin
        if (pend_prio[j] < pend_prio[sel]) sel = j;
      end
      tp = pend_prio[i];
      tb = pend_burst[i];
      ti = pend_id[i];
      pend_prio[i]    = pend_prio[sel];
      pend_burst[i]   = pend_burst[sel];
      pend_id[i]      = pend_id[sel];
      pend_prio[sel]  = tp;
      pend_burst[sel] = tb;
      pend_id[sel]    = ti;
    end
    run_wait = '0;
    sum_w = '0;
    sum_t = '0;
    for (int k = 0; k < n; k++) begin
      turn = run_wait + TIME_W'(pend_burst[k]);
      sum_w = sum_w + SUM_W'(run_wait);
      sum_t = sum_t + SUM_W'(turn);
      slots[k] = '0;
      slots[k].job_priority    = pend_prio[k];
      slots[k].job_number      = JOBNUM_W'(pend_id[k]) + JOBNUM_W'(1);
      slots[k].job_burst       = pend_burst[k];
      slots[k].waiting_time    = run_wait;
      slots[k].turnaround_time = turn;
      slots[k].overflowed      = pend_ovf;
      slots[k].last_out        = (k == n - 1);
      run_wait = turn;
    end
    if (n > 0) begin
      slots[n-1].avg_waiting    = TIME_W'(sum_w / SUM_W'(n));
      slots[n-1].avg_turnaround = TIME_W'(sum_t / SUM_W'(n));
    end
    for (int k = 0; k < n; k++) expected_slots.push_back(slots[k]);
    pend_cnt = 0;
    pend_ovf = 1'b0;
  endfunction

  function automatic void take_job(in_t job);
    if (pend_cnt < MAX_JOBS) begin
      pend_burst[pend_cnt] = job.burst_time;
      pend_prio[pend_cnt]  = job.priority_req;
      pend_id[pend_cnt]    = 6'(pend_cnt);
      pend_cnt++;
    end else begin
      pend_ovf = 1'b1;
    end
    if (job.is_last) close_batch();
  endfunction

  task automatic cmp_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, fname, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  task automatic check_slot(out_t got);
    out_t want;
    if (expected_slots.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, got %h", $time, got);
      fail_cnt++;
    end else begin
      want = expected_slots.pop_front();
      cmp_field("job_priority", 32'(want.job_priority), 32'(got.job_priority));
      cmp_field("job_number", 32'(want.job_number), 32'(got.job_number));
      cmp_field("job_burst", 32'(want.job_burst), 32'(got.job_burst));
      cmp_field("waiting_time", 32'(want.waiting_time), 32'(got.waiting_time));
      cmp_field("turnaround_time", 32'(want.turnaround_time), 32'(got.turnaround_time));
      cmp_field("avg_waiting", 32'(want.avg_waiting), 32'(got.avg_waiting));
      cmp_field("avg_turnaround", 32'(want.avg_turnaround), 32'(got.avg_turnaround));
      cmp_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
      cmp_field("last_out", 32'(want.last_out), 32'(got.last_out));
    end
  endtask

  // accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) take_job(in_data);
      if (out_valid && out_ready) check_slot(out_data);
    end
  end

  // receiver: alternating ready and stall runs, plus the long hold on request
  int  hold_seen;
  int  hold_left;
  int  run_left;
  bit  rdy_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= hold_token;
      hold_left <= 0;
      run_left  <= 0;
      rdy_phase <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (run_left == 0) begin
      rdy_phase <= !rdy_phase;
      run_left  <= !rdy_phase ? $urandom_range(1, 30) : $urandom_range(1, 8);
      out_ready <= !rdy_phase;
    end else begin
      run_left  <= run_left - 1;
      out_ready <= rdy_phase;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("priority_schedule_times_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_job(logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio, logic last);
    int gap;
    in_t job;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    job.burst_time   = burst;
    job.priority_req = prio;
    job.is_last      = last;
    in_valid <= 1'b1;
    in_data  <= job;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_schedule();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_slots.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_job_extremes();
    send_job(16'hFFFF, 8'hFF, 1'b1);
    send_job(16'h0000, 8'h00, 1'b1);
    send_job(16'h5555, 8'hAA, 1'b1);
    drain_schedule();
  endtask

  task automatic test_equal_priorities();
    send_job(16'd10, 8'd5, 1'b0);
    send_job(16'd20, 8'd3, 1'b0);
    send_job(16'd30, 8'd5, 1'b0);
    send_job(16'd40, 8'd3, 1'b0);
    send_job(16'd50, 8'd1, 1'b0);
    send_job(16'd60, 8'd5, 1'b1);
    send_job(16'd7, 8'd9, 1'b0);
    send_job(16'd8, 8'd9, 1'b0);
    send_job(16'd9, 8'd9, 1'b1);
    drain_schedule();
  endtask

  task automatic test_mixed_values();
    send_job(16'hAAAA, 8'h55, 1'b0);
    send_job(16'h0000, 8'hFF, 1'b0);
    send_job(16'hFFFF, 8'h00, 1'b0);
    send_job(16'h5555, 8'hAA, 1'b1);
    drain_schedule();
  endtask

  // receiver held off while a full batch and an overflowing one are offered; a second overflowing batch follows
  task automatic test_long_stall_and_overflow();
    hold_token <= hold_token + 1;
    for (int k = 0; k < MAX_JOBS; k++) send_job(16'hFFFF, 8'(MAX_JOBS - k), k == MAX_JOBS - 1);
    for (int k = 0; k < MAX_JOBS + 2; k++)
      send_job(16'($urandom), 8'($urandom_range(0, 7)), k == MAX_JOBS + 1);
    drain_schedule();
    for (int k = 0; k <= MAX_JOBS; k++)
      send_job(16'($urandom), 8'($urandom), k == MAX_JOBS);
    drain_schedule();
  endtask

  task automatic test_random_batches();
    int n;
    int sel;
    int prio_hi;
    logic [BURST_W-1:0] burst;
    while (rand_sent < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) n = $urandom_range(1, 6);
      else if (sel < 90) n = $urandom_range(7, 20);
      else if (sel < 97) n = $urandom_range(21, MAX_JOBS);
      else n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      prio_hi = ($urandom_range(0, 2) == 0) ? 3 : 255;
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 3))
          0: burst = 16'($urandom_range(0, 15));
          1: burst = 16'hFFFF - 16'($urandom_range(0, 15));
          default: burst = 16'($urandom);
        endcase
        send_job(burst, 8'($urandom_range(0, prio_hi)), k == n - 1);
        rand_sent++;
      end
      if ($urandom_range(0, 9) == 0) drain_schedule();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    pend_cnt    = 0;
    pend_ovf    = 1'b0;
    fail_cnt    = 0;
    idle_cycles = 0;
    burst_left  = 0;
    rand_sent   = 0;
    hold_token  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_job_extremes();
    test_equal_priorities();
    test_mixed_values();
    test_long_stall_and_overflow();
    test_random_batches();
    drain_schedule();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_cnt == 0 && expected_slots.size() == 0) begin
      $display("priority_schedule_times_top test passed");
    end else begin
      $display("priority_schedule_times_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pst_pkg.sv
sv/pst_ram.sv
sv/pst_div.sv
sv/priority_schedule_times_top.sv
sim/tb_top.sv
